FILE: sv/crc16_packet_framer_defines.svh
// Assertion macros shared by the framer modules.
`ifndef CRC16_PACKET_FRAMER_DEFINES_SVH
`define CRC16_PACKET_FRAMER_DEFINES_SVH

// Checked only outside reset.
`define CPF_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define CPF_CHECK_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: sv/cpf_pkg.sv
package cpf_pkg;

   localparam int unsigned MAX_PAYLOAD = 1024;
   localparam int LEN_W  = 11;
   localparam int BYTE_W = 8;
   localparam int CRC_W  = 16;

   localparam logic [BYTE_W-1:0] SOH_BYTE = 8'h01;
   localparam logic [BYTE_W-1:0] ACK_BYTE = 8'h06;
   localparam logic [CRC_W-1:0]  CRC_POLY = 16'h1021;

   // Item kinds
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_REPLY   = 2'd2;

   // Longest run of results one item can cause
   localparam int MAX_RUN = 6;
   localparam int CNT_W   = $clog2(MAX_RUN + 1);

   typedef enum logic [1:0] {
      ST_FRAME_BYTE = 2'd0,
      ST_ACK        = 2'd1,
      ST_NAK        = 2'd2,
      ST_OUTSIDE    = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      status_type        status;
      logic              frame_end;
      logic              last;
   } result_type;

   typedef struct packed {
      logic [CNT_W-1:0]             count;
      result_type [MAX_RUN-1:0]     entry;
   } run_type;

   typedef logic [255:0][CRC_W-1:0] crc_tab_type;

   // Entry x holds x * x^(8+shifts) mod the generator polynomial.
   function automatic crc_tab_type build_crc_tab(int unsigned shifts);
      crc_tab_type       tab;
      logic [CRC_W-1:0]  r;
      for (int x = 0; x < 256; x++) begin
         r = {8'(x), 8'h00};
         for (int unsigned i = 0; i < shifts; i++) begin
            r = r[CRC_W-1] ? ({r[CRC_W-2:0], 1'b0} ^ CRC_POLY) : {r[CRC_W-2:0], 1'b0};
         end
         tab[x] = r;
      end
      return tab;
   endfunction

   // Byte weighted by x^16, x^24 and x^32
   localparam crc_tab_type CRC_TAB_X16 = build_crc_tab(8);
   localparam crc_tab_type CRC_TAB_X24 = build_crc_tab(16);
   localparam crc_tab_type CRC_TAB_X32 = build_crc_tab(24);

endpackage

FILE: sv/cpf_engine.sv
`include "crc16_packet_framer_defines.svh"

module cpf_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [cpf_pkg::LEN_W-1:0]     req_payload_length,
   input  logic [cpf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [cpf_pkg::BYTE_W-1:0]    req_reply_byte,
   input  logic                          req_timed_out,
   output logic                          run_valid,
   output cpf_pkg::run_type              run,
   input  logic                          run_ready
);

   logic                          in_valid_ff, in_valid_in;
   logic [1:0]                    in_kind_ff;
   logic [cpf_pkg::LEN_W-1:0]     in_len_ff;
   logic [cpf_pkg::BYTE_W-1:0]    in_data_ff;
   logic [cpf_pkg::BYTE_W-1:0]    in_reply_ff;
   logic                          in_timeout_ff;

   logic [cpf_pkg::CRC_W-1:0]     crc_ff, crc_in;
   logic [cpf_pkg::LEN_W-1:0]     remaining_ff, remaining_in;
   logic                          open_ff, open_in;

   logic                          req_accept;
   logic                          in_fire;
   logic [cpf_pkg::LEN_W-1:0]     len_clamped;
   logic [cpf_pkg::BYTE_W-1:0]    len_hi, len_lo;
   logic [cpf_pkg::CRC_W-1:0]     crc_upd, crc_end;
   logic [cpf_pkg::LEN_W-1:0]     rem_dec;
   logic [cpf_pkg::CRC_W-1:0]     next_crc;
   logic [cpf_pkg::LEN_W-1:0]     next_remaining;
   logic                          next_open;

   assign req_accept = req_valid && !req_stall;
   // An item that causes no result retires without waiting on the serializer.
   assign in_fire    = in_valid_ff && (run_ready || (run.count == '0));
   assign req_stall  = in_valid_ff && !in_fire;
   assign run_valid  = in_valid_ff && (run.count != '0);

   assign len_clamped = (in_len_ff > cpf_pkg::LEN_W'(cpf_pkg::MAX_PAYLOAD))
                        ? cpf_pkg::LEN_W'(cpf_pkg::MAX_PAYLOAD) : in_len_ff;
   assign len_hi = cpf_pkg::BYTE_W'(len_clamped >> 8);
   assign len_lo = len_clamped[7:0];

   // One data byte folded in, and the same followed by two zero bytes.
   assign crc_upd = cpf_pkg::CRC_TAB_X16[crc_ff[15:8]] ^ {crc_ff[7:0], in_data_ff};
   assign crc_end = cpf_pkg::CRC_TAB_X32[crc_ff[15:8]]
                  ^ cpf_pkg::CRC_TAB_X24[crc_ff[7:0]]
                  ^ cpf_pkg::CRC_TAB_X16[in_data_ff];
   assign rem_dec = remaining_ff - cpf_pkg::LEN_W'(1);

   always_comb begin
      run            = '0;
      next_crc       = crc_ff;
      next_remaining = remaining_ff;
      next_open      = open_ff;
      case (in_kind_ff)
         cpf_pkg::KIND_START: begin
            run.entry[0] = '{cpf_pkg::SOH_BYTE, cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
            run.entry[1] = '{len_hi, cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
            run.entry[2] = '{len_lo, cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
            next_crc     = '0;
            if (len_clamped == '0) begin
               run.entry[3]   = '{8'(len_hi + len_lo), cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
               run.entry[4]   = '{8'h00, cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
               run.entry[5]   = '{8'h00, cpf_pkg::ST_FRAME_BYTE, 1'b1, 1'b1};
               run.count      = cpf_pkg::CNT_W'(6);
               next_remaining = '0;
               next_open      = 1'b0;
            end else begin
               run.entry[3]   = '{8'(len_hi + len_lo), cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b1};
               run.count      = cpf_pkg::CNT_W'(4);
               next_remaining = len_clamped;
               next_open      = 1'b1;
            end
         end
         cpf_pkg::KIND_PAYLOAD: begin
            if (!open_ff || (remaining_ff == '0)) begin
               run.entry[0] = '{8'h00, cpf_pkg::ST_OUTSIDE, 1'b0, 1'b1};
               run.count    = cpf_pkg::CNT_W'(1);
            end else if (rem_dec == '0) begin
               run.entry[0]   = '{in_data_ff, cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
               run.entry[1]   = '{crc_end[15:8], cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b0};
               run.entry[2]   = '{crc_end[7:0], cpf_pkg::ST_FRAME_BYTE, 1'b1, 1'b1};
               run.count      = cpf_pkg::CNT_W'(3);
               next_crc       = crc_end;
               next_remaining = '0;
               next_open      = 1'b0;
            end else begin
               run.entry[0]   = '{in_data_ff, cpf_pkg::ST_FRAME_BYTE, 1'b0, 1'b1};
               run.count      = cpf_pkg::CNT_W'(1);
               next_crc       = crc_upd;
               next_remaining = rem_dec;
            end
         end
         cpf_pkg::KIND_REPLY: begin
            run.entry[0] = '{8'h00,
                             ((in_reply_ff == cpf_pkg::ACK_BYTE) && !in_timeout_ff)
                             ? cpf_pkg::ST_ACK : cpf_pkg::ST_NAK,
                             1'b0, 1'b1};
            run.count    = cpf_pkg::CNT_W'(1);
         end
         default: begin
            run.count = '0;
         end
      endcase
   end

   assign in_valid_in  = req_accept ? 1'b1 : (in_fire ? 1'b0 : in_valid_ff);
   assign crc_in       = in_fire ? next_crc : crc_ff;
   assign remaining_in = in_fire ? next_remaining : remaining_ff;
   assign open_in      = in_fire ? next_open : open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         crc_ff       <= '0;
         remaining_ff <= '0;
         open_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         crc_ff       <= crc_in;
         remaining_ff <= remaining_in;
         open_ff      <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_kind_ff    <= req_kind;
         in_len_ff     <= req_payload_length;
         in_data_ff    <= req_data_byte;
         in_reply_ff   <= req_reply_byte;
         in_timeout_ff <= req_timed_out;
      end
   end

   `CPF_CHECK(a_open_matches_count, open_ff == (remaining_ff != '0), "frame open flag and byte count disagree")
   `CPF_CHECK(a_count_in_range, remaining_ff <= cpf_pkg::LEN_W'(cpf_pkg::MAX_PAYLOAD), "byte count above maximum payload")
   `CPF_CHECK(a_count_steps, (in_fire && (in_kind_ff == cpf_pkg::KIND_PAYLOAD) && open_ff) |=> (remaining_ff == cpf_pkg::LEN_W'($past(remaining_ff) - cpf_pkg::LEN_W'(1))), "payload byte did not decrement count")

endmodule

FILE: sv/cpf_serializer.sv
`include "crc16_packet_framer_defines.svh"

module cpf_serializer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          run_valid,
   input  cpf_pkg::run_type              run,
   output logic                          run_ready,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cpf_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_frame_end,
   output logic                          rsp_last_of_run
);

   cpf_pkg::result_type [cpf_pkg::MAX_RUN-1:0] entry_ff, entry_in;
   logic [cpf_pkg::CNT_W-1:0]                  cnt_ff, cnt_in;
   logic                                       rsp_valid_ff, rsp_valid_in;
   cpf_pkg::result_type                        rsp_ff;
   logic                                       out_load;
   logic                                       run_load;

   // Head entry moves to the output register whenever that register is empty or not stalled.
   assign out_load  = (cnt_ff != '0) && (!rsp_valid_ff || !rsp_stall);
   assign run_ready = (cnt_ff == '0) || (out_load && (cnt_ff == cpf_pkg::CNT_W'(1)));
   assign run_load  = run_valid && run_ready;

   always_comb begin
      entry_in = entry_ff;
      cnt_in   = cnt_ff;
      if (run_load) begin
         entry_in = run.entry;
         cnt_in   = run.count;
      end else if (out_load) begin
         for (int i = 0; i < cpf_pkg::MAX_RUN - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
         cnt_in = cnt_ff - cpf_pkg::CNT_W'(1);
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (out_load) begin
         rsp_ff <= entry_ff[0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_ff.data;
   assign rsp_status      = rsp_ff.status;
   assign rsp_frame_end   = rsp_ff.frame_end;
   assign rsp_last_of_run = rsp_ff.last;

   `CPF_CHECK(a_cnt_in_range, cnt_ff <= cpf_pkg::CNT_W'(cpf_pkg::MAX_RUN), "run count above longest run")
   `CPF_CHECK(a_end_is_last, rsp_valid_ff |-> (!rsp_ff.frame_end || rsp_ff.last), "frame end not on last result of run")
   `CPF_CHECK_RST(a_reset_empties, reset |=> ((cnt_ff == '0) && !rsp_valid_ff), "serializer not empty after reset")

endmodule

FILE: sv/crc16_packet_framer.sv
// Channel   Dir  Handshake            Payload
// req_      in   req_valid/req_stall  kind, payload_length, data_byte, reply_byte, timed_out
// rsp_      out  rsp_valid/rsp_stall  out_byte, status, frame_end, last_of_run
//
// An accepted item builds its run of 0 to 6 results in the input register; the
// run then passes through the serializer's run buffer to the output register.
// Results leave one per cycle while rsp_stall is low: single-result items flow
// back to back, a start item gives 4 or 6 results and a closing payload byte 3
// (the CRC with its two zero bytes is three parallel table reads).
// Reset (synchronous, active high) clears the CRC, byte count, open flag, run
// count and valid flags. While rsp_stall holds, a full run buffer keeps the
// next run in the input register and req_stall rises.
module crc16_packet_framer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic [cpf_pkg::LEN_W-1:0]     req_payload_length,
   input  logic [cpf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [cpf_pkg::BYTE_W-1:0]    req_reply_byte,
   input  logic                          req_timed_out,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cpf_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_frame_end,
   output logic                          rsp_last_of_run
);

   // Run of results for the item in the input register
   logic              run_valid;
   logic              run_ready;
   cpf_pkg::run_type  run;

   // Input register, frame state and CRC; builds the run per item.
   cpf_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_payload_length (req_payload_length),
      .req_data_byte      (req_data_byte),
      .req_reply_byte     (req_reply_byte),
      .req_timed_out      (req_timed_out),
      .run_valid          (run_valid),
      .run                (run),
      .run_ready          (run_ready)
   );

   // Run buffer and output register; one result per cycle while rsp_stall is low.
   cpf_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .run_valid       (run_valid),
      .run             (run),
      .run_ready       (run_ready),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
